// ===== sv/rbs_pkg.sv =====
// Shared types, codes and reset values for the retry backoff scheduler.
package rbs_pkg;

   localparam int unsigned CSR_ADDR_W = 8;
   localparam int unsigned CSR_DATA_W = 32;

   // op codes; the remaining code behaves as a query
   localparam logic [1:0] OP_QUERY   = 2'd0;
   localparam logic [1:0] OP_SUCCESS = 2'd1;
   localparam logic [1:0] OP_FAILURE = 2'd2;

   // register indexes
   localparam logic [CSR_ADDR_W-1:0] CSR_INITIAL_RETRY    = 8'd0;
   localparam logic [CSR_ADDR_W-1:0] CSR_MAX_RETRY        = 8'd1;
   localparam logic [CSR_ADDR_W-1:0] CSR_SUCCESS_INTERVAL = 8'd2;
   localparam logic [CSR_ADDR_W-1:0] CSR_MAX_AGE          = 8'd3;

   // register reset values
   localparam logic [31:0] RST_INITIAL_RETRY_MS    = 32'd30000;
   localparam logic [31:0] RST_MAX_RETRY_MS        = 32'd1800000;
   localparam logic [31:0] RST_SUCCESS_INTERVAL_MS = 32'd600000;
   localparam logic [31:0] RST_MAX_AGE_S           = 32'd3600;

   localparam logic [4:0] FAIL_CAP  = 5'd31;
   localparam logic [2:0] SHIFT_CAP = 3'd6;

   typedef struct packed {
      logic [1:0]  op;
      logic [63:0] now_ms;
      logic [63:0] now_wall_s;
      logic [63:0] success_wall_s;
      logic [2:0]  failure_kind;
   } req_item_type;

   typedef struct packed {
      logic        retry_is_due;
      logic        data_stale;
      logic [63:0] next_attempt_at_ms;
      logic [4:0]  failure_count;
      logic [2:0]  last_failure_kind;
      logic        have_data;
   } rsp_item_type;

   typedef struct packed {
      logic [31:0] initial_retry_ms;
      logic [31:0] max_retry_ms;
      logic [31:0] success_interval_ms;
      logic [31:0] max_age_s;
   } cfg_type;

endpackage

// ===== sv/rbs_if.sv =====
// Valid/ready channel interfaces for request, response and register write.
interface rbs_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  op;
   logic [63:0] now_ms;
   logic [63:0] now_wall_s;
   logic [63:0] success_wall_s;
   logic [2:0]  failure_kind;

   modport source (output valid, op, now_ms, now_wall_s, success_wall_s, failure_kind,
                   input ready);
   modport sink   (input valid, op, now_ms, now_wall_s, success_wall_s, failure_kind,
                   output ready);
endinterface

interface rbs_rsp_if;
   logic        valid;
   logic        ready;
   logic        retry_is_due;
   logic        data_stale;
   logic [63:0] next_attempt_at_ms;
   logic [4:0]  failure_count;
   logic [2:0]  last_failure_kind;
   logic        have_data;

   modport source (output valid, retry_is_due, data_stale, next_attempt_at_ms,
                   failure_count, last_failure_kind, have_data,
                   input ready);
   modport sink   (input valid, retry_is_due, data_stale, next_attempt_at_ms,
                   failure_count, last_failure_kind, have_data,
                   output ready);
endinterface

interface rbs_csr_if;
   logic                          valid;
   logic                          ready;
   logic [rbs_pkg::CSR_ADDR_W-1:0] addr;
   logic [rbs_pkg::CSR_DATA_W-1:0] wdata;

   modport source (output valid, addr, wdata, input ready);
   modport sink   (input valid, addr, wdata, output ready);
endinterface

// ===== sv/rbs_csr.sv =====
// Configuration register file: four 32-bit registers with reset values.
module rbs_csr (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           wr_en,
   input  logic [rbs_pkg::CSR_ADDR_W-1:0] wr_addr,
   input  logic [rbs_pkg::CSR_DATA_W-1:0] wr_data,
   output rbs_pkg::cfg_type               cfg
);

   rbs_pkg::cfg_type cfg_ff;
   rbs_pkg::cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         case (wr_addr)
            rbs_pkg::CSR_INITIAL_RETRY:    cfg_in.initial_retry_ms    = wr_data;
            rbs_pkg::CSR_MAX_RETRY:        cfg_in.max_retry_ms        = wr_data;
            rbs_pkg::CSR_SUCCESS_INTERVAL: cfg_in.success_interval_ms = wr_data;
            rbs_pkg::CSR_MAX_AGE:          cfg_in.max_age_s           = wr_data;
            default: ;  // unmapped index: dropped
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.initial_retry_ms    <= rbs_pkg::RST_INITIAL_RETRY_MS;
         cfg_ff.max_retry_ms        <= rbs_pkg::RST_MAX_RETRY_MS;
         cfg_ff.success_interval_ms <= rbs_pkg::RST_SUCCESS_INTERVAL_MS;
         cfg_ff.max_age_s           <= rbs_pkg::RST_MAX_AGE_S;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

// ===== sv/rbs_sched.sv =====
// Scheduler state and the single-pass update/result logic for one item.
module rbs_sched (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  fire,
   input  rbs_pkg::req_item_type item,
   input  rbs_pkg::cfg_type      cfg,
   output rbs_pkg::rsp_item_type result
);

   logic [63:0] next_ff,  next_in;
   logic        valid_ff, valid_in;
   logic [63:0] epoch_ff, epoch_in;
   logic [4:0]  count_ff, count_in;
   logic [2:0]  kind_ff,  kind_in;

   logic [2:0]  sh;
   logic [37:0] shifted;
   logic [31:0] delay;
   logic [64:0] fail_sum;
   logic [64:0] succ_sum;
   logic [64:0] age;
   logic        now_max;
   logic        due;
   logic        stale;

   always_comb begin
      // failure delay: shift is min(count, 6) taken from the count before the bump
      sh       = (count_ff >= 5'd6) ? rbs_pkg::SHIFT_CAP : count_ff[2:0];
      shifted  = {6'd0, cfg.initial_retry_ms} << sh;
      delay    = (shifted > {6'd0, cfg.max_retry_ms}) ? cfg.max_retry_ms : shifted[31:0];
      fail_sum = {1'b0, item.now_ms} + {33'd0, delay};
      succ_sum = {1'b0, item.now_ms} + {33'd0, cfg.success_interval_ms};
      now_max  = &item.now_ms;

      next_in  = next_ff;
      valid_in = valid_ff;
      epoch_in = epoch_ff;
      count_in = count_ff;
      kind_in  = kind_ff;
      // after a schedule, now >= now +sat d only when d is zero or now is all-ones
      due      = (item.now_ms >= next_ff);

      case (item.op)
         rbs_pkg::OP_SUCCESS: begin
            valid_in = 1'b1;
            epoch_in = item.success_wall_s;
            next_in  = succ_sum[64] ? '1 : succ_sum[63:0];
            count_in = '0;
            kind_in  = '0;
            due      = (cfg.success_interval_ms == '0) || now_max;
         end
         rbs_pkg::OP_FAILURE: begin
            count_in = (count_ff < rbs_pkg::FAIL_CAP) ? count_ff + 5'd1 : count_ff;
            next_in  = fail_sum[64] ? '1 : fail_sum[63:0];
            kind_in  = item.failure_kind;
            due      = (delay == '0) || now_max;
         end
         default: ;  // query, or unused code
      endcase

      age   = {1'b0, item.now_wall_s} - {1'b0, epoch_in};
      stale = !valid_in || (epoch_in == '0) || (cfg.max_age_s == '0) || age[64] ||
              (age[63:0] > {32'd0, cfg.max_age_s});

      result.retry_is_due       = due;
      result.data_stale         = stale;
      result.next_attempt_at_ms = next_in;
      result.failure_count      = count_in;
      result.last_failure_kind  = kind_in;
      result.have_data          = valid_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         next_ff  <= '0;
         valid_ff <= 1'b0;
         epoch_ff <= '0;
         count_ff <= '0;
         kind_ff  <= '0;
      end else if (fire) begin
         next_ff  <= next_in;
         valid_ff <= valid_in;
         epoch_ff <= epoch_in;
         count_ff <= count_in;
         kind_ff  <= kind_in;
      end
   end

endmodule

// ===== sv/retry_backoff_scheduler.sv =====
// Top level of the capped exponential backoff retry scheduler.
// Throughput is one item per clock while the response side does not stall; an
// accepted item passes through the input register and then the result register
// on its way to the response channel. The whole update - shift of the base delay,
// cap against the maximum, 64-bit saturating schedule add and the staleness
// compare - is evaluated in one pass between the input register and the result
// register, and the scheduler state commits in the same cycle, so a following
// item sees it at once. The result register parts the two sides: a new item is
// taken while a finished result still waits, and req ready drops only when both
// registers are full and the response side stalls. Register writes are taken every
// cycle (csr ready is always high) and must only happen while the block is idle.
module retry_backoff_scheduler (
   input  logic clock,
   input  logic reset,
   rbs_req_if.sink   req_ch,
   rbs_rsp_if.source rsp_ch,
   rbs_csr_if.sink   csr_ch
);

   rbs_pkg::cfg_type      cfg;
   rbs_pkg::req_item_type req_item;
   rbs_pkg::rsp_item_type result;

   // input register
   logic                  s1_valid_ff, s1_valid_in;
   rbs_pkg::req_item_type s1_item_ff;
   // result register
   logic                  s2_valid_ff, s2_valid_in;
   rbs_pkg::rsp_item_type s2_item_ff;

   logic s2_free;
   logic s1_adv;
   logic req_take;

   assign csr_ch.ready = 1'b1;

   rbs_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (csr_ch.valid),
      .wr_addr (csr_ch.addr),
      .wr_data (csr_ch.wdata),
      .cfg     (cfg)
   );

   always_comb begin
      req_item.op             = req_ch.op;
      req_item.now_ms         = req_ch.now_ms;
      req_item.now_wall_s     = req_ch.now_wall_s;
      req_item.success_wall_s = req_ch.success_wall_s;
      req_item.failure_kind   = req_ch.failure_kind;
   end

   // handshake: item moves to the result register when that one is empty or draining
   assign s2_free      = !s2_valid_ff || rsp_ch.ready;
   assign s1_adv       = s1_valid_ff && s2_free;
   assign req_ch.ready = !s1_valid_ff || s1_adv;
   assign req_take     = req_ch.valid && req_ch.ready;

   assign s1_valid_in = req_take || (s1_valid_ff && !s1_adv);
   assign s2_valid_in = s1_adv || (s2_valid_ff && !rsp_ch.ready);

   rbs_sched u_sched (
      .clock  (clock),
      .reset  (reset),
      .fire   (s1_adv),
      .item   (s1_item_ff),
      .cfg    (cfg),
      .result (result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
         s2_valid_ff <= s2_valid_in;
      end
   end

   // payload registers, no reset
   always_ff @(posedge clock) begin
      if (req_take) begin
         s1_item_ff <= req_item;
      end
      if (s1_adv) begin
         s2_item_ff <= result;
      end
   end

   assign rsp_ch.valid              = s2_valid_ff;
   assign rsp_ch.retry_is_due       = s2_item_ff.retry_is_due;
   assign rsp_ch.data_stale         = s2_item_ff.data_stale;
   assign rsp_ch.next_attempt_at_ms = s2_item_ff.next_attempt_at_ms;
   assign rsp_ch.failure_count      = s2_item_ff.failure_count;
   assign rsp_ch.last_failure_kind  = s2_item_ff.last_failure_kind;
   assign rsp_ch.have_data          = s2_item_ff.have_data;

endmodule

// ===== sv/rbs_checker.sv =====
// Port-level assertions for the retry backoff scheduler, bound to the top level.
module rbs_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [63:0] rsp_next,
   input logic [4:0]  rsp_count,
   input logic [2:0]  rsp_kind,
   input logic        rsp_have,
   input logic        rsp_stale
);

   // nothing comes out right after reset
   a_reset_quiet: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("response valid after reset");

   // a stalled result holds
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_next) && $stable(rsp_count))
      else $error("stalled response changed");

   // zero streak means no failure since the last success
   a_kind_clear: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_count == 5'd0) |-> (rsp_kind == 3'd0))
      else $error("failure kind set with zero streak");

   // no success ever recorded means stale
   a_stale: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_have |-> rsp_stale)
      else $error("fresh data without a success");

endmodule

bind retry_backoff_scheduler rbs_checker u_rbs_checker (
   .clock     (clock),
   .reset     (reset),
   .rsp_valid (rsp_ch.valid),
   .rsp_ready (rsp_ch.ready),
   .rsp_next  (rsp_ch.next_attempt_at_ms),
   .rsp_count (rsp_ch.failure_count),
   .rsp_kind  (rsp_ch.last_failure_kind),
   .rsp_have  (rsp_ch.have_data),
   .rsp_stale (rsp_ch.data_stale)
);
